/* design/smpq_pkg.sv */
`default_nettype none

package smpq_pkg;

    // Default sizes of the queue.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF = 16;

    // Command codes carried on the request channel.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes carried on the response channel.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Shift control broadcast from the top level to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } smpq_ctl_t;

endpackage

`default_nettype wire

/* design/smpq_if.sv */
`default_nettype none

// Request channel: one beat is one insert or remove command.
interface smpq_req_if #(
    parameter int DW = 32,
    parameter int PW = 16
) ();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic signed [DW-1:0] in_data;
    logic signed [PW-1:0] in_priority;

    modport source (output valid, cmd, in_data, in_priority, input ready);
    modport sink   (input valid, cmd, in_data, in_priority, output ready);
endinterface

// Response channel: one beat per accepted command.
interface smpq_rsp_if #(
    parameter int DW = 32,
    parameter int PW = 16,
    parameter int CW = 5
) ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [DW-1:0] out_data;
    logic signed [PW-1:0] out_priority;
    logic [CW-1:0]        occupancy;

    modport source (output valid, status, out_data, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_data, out_priority, occupancy, output ready);
endinterface

`default_nettype wire

/* design/stable_min_priority_queue.sv */
// Stable minimum priority queue built as a row of DEPTH cells kept sorted by
// ascending signed priority, the lowest at cell 0. Every cell compares its
// priority with an incoming entry at once, so an insert or a remove updates
// every cell together. Entries of equal priority leave in arrival order. Each
// request gives exactly one response beat, held in a single output register:
// the request side is ready whenever that register is empty or is being read
// in the same cycle, so with the response side always ready the rate is one
// beat per cycle, and each response appears in the cycle after its request.
// A remove from an empty queue reports empty; an insert into a full queue
// is dropped and reports full. Data and priority of a response are zero
// unless it reports a removal.
`default_nettype none

module stable_min_priority_queue #(
    parameter int DEPTH      = smpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = smpq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = smpq_pkg::PRIO_WIDTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    smpq_req_if.sink   req,
    smpq_rsp_if.source rsp
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [1:0]       status_reg;
    logic signed [DATA_WIDTH-1:0] rdata_reg;
    logic signed [PRIO_WIDTH-1:0] rprio_reg;
    logic [CNT_W-1:0] occ_reg;

    logic       accept;
    logic       full;
    logic       empty;
    smpq_ctl_t  ctl;
    logic [1:0] status_next;

    logic [DEPTH-1:0]             gt;
    logic [DEPTH-1:0]             occupied;
    logic [DEPTH-1:0]             prev_gt;
    logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic signed [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic signed [DATA_WIDTH-1:0] prev_data [DEPTH];
    logic signed [PRIO_WIDTH-1:0] prev_prio [DEPTH];
    logic signed [DATA_WIDTH-1:0] next_data [DEPTH];
    logic signed [PRIO_WIDTH-1:0] next_prio [DEPTH];

    // Handshake and queue state decode.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ctl.ins   = accept && (req.cmd == CMD_INSERT) && !full;
    assign ctl.rem   = accept && (req.cmd == CMD_REMOVE) && !empty;

    // Neighbor wiring of the cell row; the ends see the request or themselves.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign occupied[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_gt[i]   = 1'b0;
                assign prev_data[i] = req.in_data;
                assign prev_prio[i] = req.in_priority;
            end
            else
            begin : g_body
                assign prev_gt[i]   = gt[i-1];
                assign prev_data[i] = cell_data[i-1];
                assign prev_prio[i] = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_data[i] = cell_data[i];
                assign next_prio[i] = cell_prio[i];
            end
            else
            begin : g_mid
                assign next_data[i] = cell_data[i+1];
                assign next_prio[i] = cell_prio[i+1];
            end

            smpq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .PRIO_WIDTH (PRIO_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (occupied[i]),
                .new_data  (req.in_data),
                .new_prio  (req.in_priority),
                .prev_gt   (prev_gt[i]),
                .prev_data (prev_data[i]),
                .prev_prio (prev_prio[i]),
                .next_data (next_data[i]),
                .next_prio (next_prio[i]),
                .gt        (gt[i]),
                .data      (cell_data[i]),
                .prio      (cell_prio[i])
            );
        end
    endgenerate

    // Occupancy and status of the accepted beat.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_INSERTED;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        case (req.cmd)
            CMD_INSERT: status_next = full ? ST_FULL : ST_INSERTED;
            CMD_REMOVE: status_next = empty ? ST_EMPTY : ST_REMOVED;
            default:    status_next = ST_INSERTED;
        endcase
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp.ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, loaded on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            occ_reg    <= count_next;
            rdata_reg  <= ctl.rem ? cell_data[0] : '0;
            rprio_reg  <= ctl.rem ? cell_prio[0] : '0;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_data     = rdata_reg;
    assign rsp.out_priority = rprio_reg;
    assign rsp.occupancy    = occ_reg;

    // The stored count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // An empty report leaves nothing stored and carries no entry.
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (status_reg == ST_EMPTY) |->
            (occ_reg == '0) && (rdata_reg == '0) && (rprio_reg == '0))
        else $error("empty response with stored entries or data");

    // A dropped insert only happens when every cell is in use.
    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (status_reg == ST_FULL) |-> (occ_reg == CNT_W'(DEPTH)))
        else $error("full response below depth");

    // The count changes only on an accepted beat; the code moves it by one at most.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request beat");

endmodule

`default_nettype wire

/* design/smpq_cell.sv */
`default_nettype none

module smpq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 16
) (
    input  wire                          clk,
    input  wire smpq_pkg::smpq_ctl_t     ctl,
    input  wire                          occupied,
    input  wire signed [DATA_WIDTH-1:0]  new_data,
    input  wire signed [PRIO_WIDTH-1:0]  new_prio,
    input  wire                          prev_gt,
    input  wire signed [DATA_WIDTH-1:0]  prev_data,
    input  wire signed [PRIO_WIDTH-1:0]  prev_prio,
    input  wire signed [DATA_WIDTH-1:0]  next_data,
    input  wire signed [PRIO_WIDTH-1:0]  next_prio,
    output logic                         gt,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic signed [PRIO_WIDTH-1:0] prio
);
    import smpq_pkg::*;

    logic signed [DATA_WIDTH-1:0] data_reg, data_next;
    logic signed [PRIO_WIDTH-1:0] prio_reg, prio_next;

    // The new entry goes ahead of this cell when the cell is free or holds a
    // strictly higher priority; equal priorities stay ahead of the new entry.
    assign gt = !occupied || (prio_reg > new_prio);

    // An insert shifts the cells at and after the insertion point back by one;
    // the first such cell takes the new entry. A remove shifts all forward.
    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctl.ins && gt)
        begin
            if (prev_gt)
            begin
                data_next = prev_data;
                prio_next = prev_prio;
            end
            else
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
        end
        else if (ctl.rem)
        begin
            data_next = next_data;
            prio_next = next_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

`default_nettype wire
